// ----- design/mie_pkg.sv -----
`timescale 1ns / 1ps

package mie_pkg;

   localparam logic [4:0] MODE_LUI    = 5'd0;
   localparam logic [4:0] MODE_ORI    = 5'd1;
   localparam logic [4:0] MODE_ANDI   = 5'd2;
   localparam logic [4:0] MODE_XORI   = 5'd3;
   localparam logic [4:0] MODE_ADDI   = 5'd4;
   localparam logic [4:0] MODE_ADDIU  = 5'd5;
   localparam logic [4:0] MODE_SLTI   = 5'd6;
   localparam logic [4:0] MODE_SLTIU  = 5'd7;
   localparam logic [4:0] MODE_BEQ    = 5'd8;
   localparam logic [4:0] MODE_BNE    = 5'd9;
   localparam logic [4:0] MODE_BGEZ   = 5'd10;
   localparam logic [4:0] MODE_BLTZ   = 5'd11;
   localparam logic [4:0] MODE_BLTZAL = 5'd12;
   localparam logic [4:0] MODE_BGEZAL = 5'd13;
   localparam logic [4:0] MODE_BGTZ   = 5'd14;
   localparam logic [4:0] MODE_BLEZ   = 5'd15;
   localparam logic [4:0] MODE_LB     = 5'd16;
   localparam logic [4:0] MODE_LBU    = 5'd17;
   localparam logic [4:0] MODE_LH     = 5'd18;
   localparam logic [4:0] MODE_LHU    = 5'd19;
   localparam logic [4:0] MODE_LW     = 5'd20;
   localparam logic [4:0] MODE_SB     = 5'd21;
   localparam logic [4:0] MODE_SH     = 5'd22;
   localparam logic [4:0] MODE_SW     = 5'd23;

   localparam logic [1:0] MEM_OP_NONE  = 2'd0;
   localparam logic [1:0] MEM_OP_LOAD  = 2'd1;
   localparam logic [1:0] MEM_OP_STORE = 2'd2;

   localparam logic [2:0] MEM_SIZE_NONE = 3'd0;
   localparam logic [2:0] MEM_SIZE_BYTE = 3'd1;
   localparam logic [2:0] MEM_SIZE_HALF = 3'd2;
   localparam logic [2:0] MEM_SIZE_WORD = 3'd4;

   localparam logic [1:0] EXC_NONE     = 2'd0;
   localparam logic [1:0] EXC_OVERFLOW = 2'd1;
   localparam logic [1:0] EXC_ADDR_LD  = 2'd2;
   localparam logic [1:0] EXC_ADDR_ST  = 2'd3;

   localparam logic [4:0]  LINK_REG          = 5'd31;
   localparam logic [31:0] LINK_OFFSET       = 32'd8;
   localparam logic [31:0] TRAP_ADDRESS_INIT = 32'hBFC0_0380;

   typedef struct packed {
      logic [4:0]  mode;
      logic [31:0] instruction;
      logic [31:0] rs_value;
      logic [31:0] rt_value;
      logic [31:0] pc;
      logic        status_exl;
   } req_type;

   typedef struct packed {
      logic        reg_write;
      logic [4:0]  dest_reg;
      logic [31:0] reg_value;
      logic        pc_redirect;
      logic [31:0] new_pc;
      logic [1:0]  mem_op;
      logic [2:0]  mem_size;
      logic [31:0] mem_addr;
      logic [31:0] store_data;
      logic        load_signed;
      logic [1:0]  exc_code;
      logic        trap_taken;
   } rsp_type;

endpackage

// ----- design/mie_alu.sv -----
`timescale 1ns / 1ps

module mie_alu (
   input  mie_pkg::req_type req,
   input  logic [31:0]      trap_address,
   output mie_pkg::rsp_type rsp
);

   logic [4:0]  rt_num;
   logic [31:0] zimm;
   logic [31:0] simm;
   logic [31:0] sum;
   logic [31:0] target;
   logic        overflow;
   logic        rs_neg;
   logic        rs_zero;
   logic        take;
   logic        fault;
   logic        misaligned;
   logic [2:0]  size;

   assign rt_num   = req.instruction[20:16];
   assign zimm     = {16'h0000, req.instruction[15:0]};
   assign simm     = {{16{req.instruction[15]}}, req.instruction[15:0]};
   assign sum      = req.rs_value + simm;
   assign target   = req.pc + {simm[29:0], 2'b00};
   assign overflow = (req.rs_value[31] == simm[31]) && (sum[31] != req.rs_value[31]);
   assign rs_neg   = req.rs_value[31];
   assign rs_zero  = (req.rs_value == 32'h0000_0000);

   always_comb begin
      case (req.mode)
         mie_pkg::MODE_LB, mie_pkg::MODE_LBU, mie_pkg::MODE_SB: begin
            size = mie_pkg::MEM_SIZE_BYTE;
         end
         mie_pkg::MODE_LH, mie_pkg::MODE_LHU, mie_pkg::MODE_SH: begin
            size = mie_pkg::MEM_SIZE_HALF;
         end
         default: begin
            size = mie_pkg::MEM_SIZE_WORD;
         end
      endcase
   end

   always_comb begin
      case (size)
         mie_pkg::MEM_SIZE_BYTE: misaligned = 1'b0;
         mie_pkg::MEM_SIZE_HALF: misaligned = sum[0];
         default:                misaligned = |sum[1:0];
      endcase
   end

   always_comb begin
      rsp   = '0;
      take  = 1'b0;
      fault = 1'b0;
      case (req.mode)
         mie_pkg::MODE_LUI: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = {req.instruction[15:0], 16'h0000};
         end
         mie_pkg::MODE_ORI: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = req.rs_value | zimm;
         end
         mie_pkg::MODE_ANDI: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = req.rs_value & zimm;
         end
         mie_pkg::MODE_XORI: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = req.rs_value ^ zimm;
         end
         mie_pkg::MODE_ADDI: begin
            if (overflow) begin
               fault = 1'b1;
               rsp.exc_code = mie_pkg::EXC_OVERFLOW;
            end else begin
               rsp.reg_write = 1'b1;
               rsp.dest_reg  = rt_num;
               rsp.reg_value = sum;
            end
         end
         mie_pkg::MODE_ADDIU: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = sum;
         end
         mie_pkg::MODE_SLTI: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = {31'h0, ($signed(req.rs_value) < $signed(simm))};
         end
         mie_pkg::MODE_SLTIU: begin
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = rt_num;
            rsp.reg_value = {31'h0, (req.rs_value < simm)};
         end
         mie_pkg::MODE_BEQ:  take = (req.rs_value == req.rt_value);
         mie_pkg::MODE_BNE:  take = (req.rs_value != req.rt_value);
         mie_pkg::MODE_BGEZ: take = !rs_neg;
         mie_pkg::MODE_BLTZ: take = rs_neg;
         mie_pkg::MODE_BLTZAL: begin
            take          = rs_neg;
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = mie_pkg::LINK_REG;
            rsp.reg_value = req.pc + mie_pkg::LINK_OFFSET;
         end
         mie_pkg::MODE_BGEZAL: begin
            take          = !rs_neg;
            rsp.reg_write = 1'b1;
            rsp.dest_reg  = mie_pkg::LINK_REG;
            rsp.reg_value = req.pc + mie_pkg::LINK_OFFSET;
         end
         mie_pkg::MODE_BGTZ: take = !rs_neg && !rs_zero;
         mie_pkg::MODE_BLEZ: take = rs_neg || rs_zero;
         mie_pkg::MODE_LB, mie_pkg::MODE_LBU, mie_pkg::MODE_LH, mie_pkg::MODE_LHU,
         mie_pkg::MODE_LW: begin
            rsp.mem_addr = sum;
            rsp.dest_reg = rt_num;
            if (misaligned) begin
               fault = 1'b1;
               rsp.exc_code = mie_pkg::EXC_ADDR_LD;
            end else begin
               rsp.mem_op      = mie_pkg::MEM_OP_LOAD;
               rsp.mem_size    = size;
               rsp.load_signed = (req.mode == mie_pkg::MODE_LB) ||
                                 (req.mode == mie_pkg::MODE_LH);
            end
         end
         mie_pkg::MODE_SB, mie_pkg::MODE_SH, mie_pkg::MODE_SW: begin
            rsp.mem_addr = sum;
            if (misaligned) begin
               fault = 1'b1;
               rsp.exc_code = mie_pkg::EXC_ADDR_ST;
            end else begin
               rsp.mem_op     = mie_pkg::MEM_OP_STORE;
               rsp.mem_size   = size;
               rsp.store_data = req.rt_value;
            end
         end
         default: begin
            rsp = '0;
         end
      endcase

      if (fault && req.status_exl) begin
         rsp.exc_code = mie_pkg::EXC_NONE;
      end
      if (take) begin
         rsp.pc_redirect = 1'b1;
         rsp.new_pc      = target;
      end
      if (fault && !req.status_exl) begin
         rsp.trap_taken  = 1'b1;
         rsp.pc_redirect = 1'b1;
         rsp.new_pc      = trap_address;
      end
   end

endmodule

// ----- design/mips_itype_execute.sv -----
`timescale 1ns / 1ps

// Execute stage for MIPS32 I-type operations. One instruction beat is accepted per clock
// while req_stall stays low. The accepting edge loads the beat into an input register.
// Combinational adder and compare logic evaluates it, and the result register then takes
// the outcome unless it holds a stalled beat. The result register holds the beat until it
// is taken. Throughput is one beat per cycle while rsp_stall stays low. While a result is
// stalled, the input register can still take one more beat. Once that register also holds
// a beat, req_stall follows rsp_stall in the same cycle. The trap vector is written through
// the csr port and must only change while no beats are in flight.
module mips_itype_execute (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mie_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data
);

   mie_pkg::req_type req_ff;
   logic             req_valid_ff;
   logic             req_valid_in;
   mie_pkg::rsp_type rsp_ff;
   mie_pkg::rsp_type rsp_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [31:0]      trap_address_ff;
   logic             rsp_hold;
   logic             req_hold;

   assign rsp_hold     = rsp_valid_ff & rsp_stall;
   assign req_hold     = req_valid_ff & rsp_hold;
   assign req_stall    = req_hold;
   assign req_valid_in = req_hold ? 1'b1 : req_valid;
   assign rsp_valid_in = rsp_hold ? 1'b1 : req_valid_ff;

   mie_alu alu (
      .req          (req_ff),
      .trap_address (trap_address_ff),
      .rsp          (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         trap_address_ff <= mie_pkg::TRAP_ADDRESS_INIT;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            trap_address_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_hold) begin
         req_ff <= req_data;
      end
      if (!rsp_hold) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_valid_ff && rsp_stall |=> req_valid_ff && $stable(req_ff))
      else $error("Held input beat was lost while the result was stalled.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && req_valid_ff |=> rsp_valid_ff)
      else $error("Input beat did not advance into the result register.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trap_taken |->
         rsp_data.pc_redirect && rsp_data.new_pc == trap_address_ff &&
         rsp_data.exc_code != mie_pkg::EXC_NONE)
      else $error("Trap result without redirect to the vector or exception code.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trap_taken |->
         !rsp_data.reg_write && rsp_data.mem_op == mie_pkg::MEM_OP_NONE)
      else $error("Trapped instruction still writes a register or issues memory access.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mem_op == mie_pkg::MEM_OP_NONE |->
         rsp_data.mem_size == mie_pkg::MEM_SIZE_NONE && !rsp_data.load_signed)
      else $error("Memory size or sign given without a memory access.");
`endif

endmodule

// ----- verif/mie_checker.sv -----
`timescale 1ns / 1ps

module mie_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mie_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mie_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [31:0]      csr_write_data,
   output int               error_count,
   output int               pending
);

   mie_pkg::rsp_type expected_results[$];
   logic [31:0]      trap_vector;
   int               mismatch_count = 0;
   int               in_flight = 0;

   assign error_count = mismatch_count;
   assign pending     = in_flight;

   function automatic mie_pkg::rsp_type execute_itype(mie_pkg::req_type r,
                                                      logic [31:0] vector);
      mie_pkg::rsp_type o;
      logic [4:0]       rt_idx;
      logic [31:0]      zimm;
      logic [31:0]      simm;
      logic [31:0]      target;
      logic [31:0]      eaddr;
      logic [31:0]      sum;
      logic [2:0]       size;
      logic             taken;
      logic             trap;
      o      = '0;
      rt_idx = r.instruction[20:16];
      zimm   = {16'h0000, r.instruction[15:0]};
      simm   = {{16{r.instruction[15]}}, r.instruction[15:0]};
      target = r.pc + (simm << 2);
      eaddr  = r.rs_value + simm;
      taken  = 1'b0;
      trap   = 1'b0;
      size   = mie_pkg::MEM_SIZE_NONE;
      case (r.mode)
         mie_pkg::MODE_LUI, mie_pkg::MODE_ORI, mie_pkg::MODE_ANDI, mie_pkg::MODE_XORI,
         mie_pkg::MODE_ADDIU, mie_pkg::MODE_SLTI, mie_pkg::MODE_SLTIU: begin
            o.reg_write = 1'b1;
            o.dest_reg  = rt_idx;
            case (r.mode)
               mie_pkg::MODE_LUI:   o.reg_value = {r.instruction[15:0], 16'h0000};
               mie_pkg::MODE_ORI:   o.reg_value = r.rs_value | zimm;
               mie_pkg::MODE_ANDI:  o.reg_value = r.rs_value & zimm;
               mie_pkg::MODE_XORI:  o.reg_value = r.rs_value ^ zimm;
               mie_pkg::MODE_ADDIU: o.reg_value = eaddr;
               mie_pkg::MODE_SLTI:
                  o.reg_value = {31'd0, $signed(r.rs_value) < $signed(simm)};
               default:             o.reg_value = {31'd0, r.rs_value < simm};
            endcase
         end
         mie_pkg::MODE_ADDI: begin
            sum = r.rs_value + simm;
            if ((r.rs_value[31] == simm[31]) && (sum[31] != r.rs_value[31])) begin
               if (!r.status_exl) begin
                  o.exc_code = mie_pkg::EXC_OVERFLOW;
                  trap       = 1'b1;
               end
            end else begin
               o.reg_write = 1'b1;
               o.dest_reg  = rt_idx;
               o.reg_value = sum;
            end
         end
         mie_pkg::MODE_BEQ:  taken = (r.rs_value == r.rt_value);
         mie_pkg::MODE_BNE:  taken = (r.rs_value != r.rt_value);
         mie_pkg::MODE_BGEZ: taken = !r.rs_value[31];
         mie_pkg::MODE_BLTZ: taken = r.rs_value[31];
         mie_pkg::MODE_BLTZAL, mie_pkg::MODE_BGEZAL: begin
            taken       = (r.mode == mie_pkg::MODE_BLTZAL) ? r.rs_value[31]
                                                           : !r.rs_value[31];
            o.reg_write = 1'b1;
            o.dest_reg  = mie_pkg::LINK_REG;
            o.reg_value = r.pc + mie_pkg::LINK_OFFSET;
         end
         mie_pkg::MODE_BGTZ: taken = !r.rs_value[31] && (r.rs_value != 32'd0);
         mie_pkg::MODE_BLEZ: taken = r.rs_value[31] || (r.rs_value == 32'd0);
         mie_pkg::MODE_LB, mie_pkg::MODE_LBU, mie_pkg::MODE_LH, mie_pkg::MODE_LHU,
         mie_pkg::MODE_LW: begin
            if (r.mode == mie_pkg::MODE_LB || r.mode == mie_pkg::MODE_LBU)
               size = mie_pkg::MEM_SIZE_BYTE;
            else if (r.mode == mie_pkg::MODE_LH || r.mode == mie_pkg::MODE_LHU)
               size = mie_pkg::MEM_SIZE_HALF;
            else
               size = mie_pkg::MEM_SIZE_WORD;
            o.mem_addr = eaddr;
            o.dest_reg = rt_idx;
            if ((eaddr & ({29'd0, size} - 32'd1)) != 32'd0) begin
               if (!r.status_exl) begin
                  o.exc_code = mie_pkg::EXC_ADDR_LD;
                  trap       = 1'b1;
               end
            end else begin
               o.mem_op      = mie_pkg::MEM_OP_LOAD;
               o.mem_size    = size;
               o.load_signed = (r.mode == mie_pkg::MODE_LB) || (r.mode == mie_pkg::MODE_LH);
            end
         end
         mie_pkg::MODE_SB, mie_pkg::MODE_SH, mie_pkg::MODE_SW: begin
            if (r.mode == mie_pkg::MODE_SB) size = mie_pkg::MEM_SIZE_BYTE;
            else if (r.mode == mie_pkg::MODE_SH) size = mie_pkg::MEM_SIZE_HALF;
            else size = mie_pkg::MEM_SIZE_WORD;
            o.mem_addr = eaddr;
            if ((eaddr & ({29'd0, size} - 32'd1)) != 32'd0) begin
               if (!r.status_exl) begin
                  o.exc_code = mie_pkg::EXC_ADDR_ST;
                  trap       = 1'b1;
               end
            end else begin
               o.mem_op     = mie_pkg::MEM_OP_STORE;
               o.mem_size   = size;
               o.store_data = r.rt_value;
            end
         end
         default: ;
      endcase
      if (taken) begin
         o.pc_redirect = 1'b1;
         o.new_pc      = target;
      end
      if (trap) begin
         o.pc_redirect = 1'b1;
         o.new_pc      = vector;
         o.trap_taken  = 1'b1;
      end
      return o;
   endfunction

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         if (mismatch_count < 10)
            $display("mismatch in %s: expected %h, got %h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      mie_pkg::rsp_type exp_r;
      if (reset) begin
         expected_results.delete();
         trap_vector <= mie_pkg::TRAP_ADDRESS_INIT;
         in_flight   <= 0;
      end else begin
         if (csr_write_enable) trap_vector <= csr_write_data;
         if (req_valid && !req_stall)
            expected_results.push_back(execute_itype(req_data, trap_vector));
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               if (mismatch_count < 10) $display("result beat with no instruction pending");
               mismatch_count++;
            end else begin
               exp_r = expected_results.pop_front();
               check_field("reg_write", 32'(exp_r.reg_write), 32'(rsp_data.reg_write));
               check_field("dest_reg", 32'(exp_r.dest_reg), 32'(rsp_data.dest_reg));
               check_field("reg_value", exp_r.reg_value, rsp_data.reg_value);
               check_field("pc_redirect", 32'(exp_r.pc_redirect),
                           32'(rsp_data.pc_redirect));
               check_field("new_pc", exp_r.new_pc, rsp_data.new_pc);
               check_field("mem_op", 32'(exp_r.mem_op), 32'(rsp_data.mem_op));
               check_field("mem_size", 32'(exp_r.mem_size), 32'(rsp_data.mem_size));
               check_field("mem_addr", exp_r.mem_addr, rsp_data.mem_addr);
               check_field("store_data", exp_r.store_data, rsp_data.store_data);
               check_field("load_signed", 32'(exp_r.load_signed),
                           32'(rsp_data.load_signed));
               check_field("exc_code", 32'(exp_r.exc_code), 32'(rsp_data.exc_code));
               check_field("trap_taken", 32'(exp_r.trap_taken), 32'(rsp_data.trap_taken));
            end
         end
         in_flight <= expected_results.size();
      end
   end

endmodule

// ----- verif/mips_itype_execute_tb.sv -----
`timescale 1ns / 1ps

module mips_itype_execute_tb;

   localparam int         IDLE_LIMIT      = 500;
   localparam int         PHASE_ITEMS     = 325;
   localparam logic [4:0] MODE_UNUSED_TOP = 5'd31;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mie_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mie_pkg::rsp_type rsp_data;
   logic             csr_write_enable = 1'b0;
   logic [31:0]      csr_write_data = 32'd0;
   int               error_count;
   int               pending;
   int               idle_cycles = 0;
   bit               no_idle = 1'b0;

   mips_itype_execute u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   mie_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending          (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("mips_itype_execute_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] corner_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] corner_imm();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'h7FFF;
         2:       return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   function automatic mie_pkg::req_type make_item(logic [4:0] mode, logic [15:0] imm,
                                                  logic [31:0] rs, logic [31:0] rt,
                                                  logic [31:0] pc, logic exl);
      mie_pkg::req_type r;
      r.mode              = mode;
      r.instruction       = $urandom;
      r.instruction[15:0] = imm;
      r.rs_value          = rs;
      r.rt_value          = rt;
      r.pc                = pc;
      r.status_exl        = exl;
      return r;
   endfunction

   function automatic mie_pkg::req_type random_item();
      mie_pkg::req_type r;
      logic [31:0]      simm;
      if ($urandom_range(0, 99) < 4) r.mode = 5'($urandom_range(24, 31));
      else r.mode = 5'($urandom_range(0, 23));
      r.instruction = $urandom;
      if ($urandom_range(0, 3) == 0) r.instruction[15:0] = corner_imm();
      r.rs_value   = corner_word();
      r.rt_value   = corner_word();
      r.pc         = $urandom;
      r.status_exl = ($urandom_range(0, 3) == 0);
      simm = {{16{r.instruction[15]}}, r.instruction[15:0]};
      if ((r.mode == mie_pkg::MODE_BEQ || r.mode == mie_pkg::MODE_BNE) &&
          $urandom_range(0, 1) == 1)
         r.rt_value = r.rs_value;
      // Most memory accesses get a word aligned effective address.
      if (r.mode >= mie_pkg::MODE_LB && r.mode <= mie_pkg::MODE_SW &&
          $urandom_range(0, 2) != 0)
         r.rs_value = ($urandom & 32'hFFFF_FFFC) - simm;
      // Put addi operands near the signed limits so overflow happens often.
      if (r.mode == mie_pkg::MODE_ADDI && $urandom_range(0, 1) == 1)
         r.rs_value = ($urandom_range(0, 1) ? 32'h7FFF_8000 : 32'h8000_0000)
                      + 32'($urandom_range(0, 65535));
      return r;
   endfunction

   task automatic send_instruction(mie_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_trap_vector(logic [31:0] vector);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= vector;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 4);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      logic [31:0] vector;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (reset);

      // Directed beats run with the trap vector left at its reset value.
      send_instruction(make_item(mie_pkg::MODE_LUI, 16'hFFFF, 32'h0, 32'h0, 32'h0, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_ORI, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                                 32'hFFFF_FFFC, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_ANDI, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_XORI, 16'h8000, 32'hFFFF_FFFF, 32'h0,
                                 $urandom, 1'b1));
      send_instruction(make_item(mie_pkg::MODE_ADDI, 16'h0001, 32'h7FFF_FFFF, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_ADDI, 16'h8000, 32'h8000_0000, 32'h0,
                                 $urandom, 1'b1));
      send_instruction(make_item(mie_pkg::MODE_ADDI, 16'hFFFF, 32'h0000_0001, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_ADDIU, 16'h0001, 32'hFFFF_FFFF, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_SLTI, 16'h8000, 32'h8000_0000, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_SLTIU, 16'hFFFF, 32'h0, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BEQ, 16'h8000, 32'h1234_5678, 32'h1234_5678,
                                 32'h0, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BNE, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BGEZ, 16'h7FFF, 32'h0, 32'h0,
                                 32'hFFFF_FFFC, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BLTZ, 16'hFFFF, 32'h8000_0000, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BLTZAL, 16'h0004, 32'h0, 32'h0,
                                 32'hFFFF_FFFC, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BGEZAL, 16'h8000, 32'h7FFF_FFFF, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BGTZ, 16'h0010, 32'h0, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_BLEZ, 16'h0010, 32'h0, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_LB, 16'h0001, 32'h0, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_LBU, 16'h0000, 32'hFFFF_FFFF, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_LH, 16'h0001, 32'h0, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_LHU, 16'h0002, 32'hFFFF_FFFE, 32'h0,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_LW, 16'hFFFF, 32'h0, 32'h0,
                                 $urandom, 1'b1));
      send_instruction(make_item(mie_pkg::MODE_SB, 16'h7FFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_SH, 16'h0003, 32'h0, 32'hFFFF_FFFF,
                                 $urandom, 1'b0));
      send_instruction(make_item(mie_pkg::MODE_SW, 16'hFFFC, 32'h4, 32'hFFFF_FFFF,
                                 $urandom, 1'b0));
      send_instruction(make_item(MODE_UNUSED_TOP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 1'b0));

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       vector = 32'h0000_0000;
            1:       vector = 32'hFFFF_FFFF;
            2:       vector = mie_pkg::TRAP_ADDRESS_INIT;
            default: vector = $urandom;
         endcase
         set_trap_vector(vector);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_instruction(random_item());
         end
      end
      no_idle = 1'b0;

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("mips_itype_execute_tb: done, clean");
      end else begin
         $display("mips_itype_execute_tb: done, errors");
      end
      $finish;
   end

endmodule
